// ===== hw/rtl/glg_pkg.sv =====
// glg_pkg: constants and types shared by the gated level-to-gain block.
// No dependencies; imported by gated_level_to_gain and its checker.
`default_nettype none

package glg_pkg;

  // Stream payload widths
  localparam int unsigned POWER_W    = 31;
  localparam int unsigned IN_TDATA_W = 32;
  localparam int unsigned GAIN_W     = 32;
  localparam int unsigned LEVEL_W    = 18;
  localparam int unsigned OUT_TDATA_W = 56;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DB_W       = 16;
  localparam int unsigned LIMIT_W    = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET = 2'd0,
    CFG_GATE   = 2'd1,
    CFG_LIMIT  = 2'd2
  } cfg_idx_e;

  localparam logic signed [DB_W-1:0]  TARGET_RST = -16'sd4608;
  localparam logic signed [DB_W-1:0]  GATE_RST   = -16'sd15360;
  localparam logic [LIMIT_W-1:0]      LIMIT_RST  = 15'd3072;

  // log2 offset 126.94269504 * 2^23, integer and Q16 fraction
  localparam logic [GAIN_W-1:0] LOG_OFFSET_INT  = 32'd1064872507;
  localparam int unsigned       LOG_OFFSET_FRAC = 10093;

  // 10*log10(2) * 256 * 2^20, fits 31-bit signed
  localparam int unsigned LCOEF_W    = 31;
  localparam logic signed [LCOEF_W-1:0] LEVEL_COEF = 31'sd808071242;
  // 2^23 * log2(10) / (20*256) in Q16, fits 30-bit signed
  localparam int unsigned GCOEF_W    = 30;
  localparam logic signed [GCOEF_W-1:0] GAIN_COEF = 30'sd356689313;

  // Internal widths
  localparam int unsigned D_W     = 32;              // power_bits - offset
  localparam int unsigned LPROD_W = D_W + LCOEF_W;   // 63
  localparam int unsigned LSHIFT  = 43;
  localparam int unsigned DIFF_W  = 19;              // target - level
  localparam int unsigned GPROD_W = DB_W + GCOEF_W;  // 46
  localparam int unsigned GSHIFT  = 16;

endpackage : glg_pkg

`default_nettype wire

// ===== hw/rtl/glg_mul.sv =====
// glg_mul: registered signed multiplier with load enable, one pipeline stage.
// No package dependency.
`default_nettype none

module glg_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 31
) (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic signed [AW-1:0]  a_i,
  input  wire logic signed [BW-1:0]  b_i,
  output logic signed [AW+BW-1:0]    p_o
);

  logic signed [AW+BW-1:0] p_d, p_q;

  // full-width signed product, both operands sign-extended
  always_comb begin
    p_d = (AW+BW)'(a_i) * (AW+BW)'(b_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule : glg_mul

`default_nettype wire

// ===== hw/rtl/gated_level_to_gain.sv =====
// gated_level_to_gain: gated gain computer with fast bit-pattern log/exp.
// Depends on glg_pkg and glg_mul.
//
//  Channel | Dir | Handshake             | Payload (lsb first)
//  s_axis  | in  | tvalid/tready         | tdata: power_bits[30:0], pad[31]
//  m_axis  | out | tvalid/tready         | tdata: gain_bits[31:0], level_db[49:32],
//          |     |                       |        pad[55:50]; tuser: gated
//  cfg     | in  | cfg_we_i              | cfg_idx_i, cfg_wdata_i (no read-back)
//
// Five register stages; an accepted request moves through them in order to
// m_axis_tvalid_o, one request per cycle sustained while m_axis_tready_i
// stays high. The two multipliers (level scale, gain scale) each own a stage
// and set the stage boundaries. Reset clears the stage valid bits and loads
// the register defaults. Each stage loads when it is empty or the next stage
// loads, so an m_axis stall fills bubbles first and only then drops s_axis_tready_o.
`default_nettype none

module gated_level_to_gain (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // input stream: [30:0] power_bits, [31] zero pad
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  wire logic [glg_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // output stream: [31:0] gain_bits, [49:32] level_db, [55:50] zero pad
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  output logic [glg_pkg::OUT_TDATA_W-1:0]        m_axis_tdata_o,
  // [0] gated
  output logic                                   m_axis_tuser_o,
  // configuration writes
  input  wire logic                              cfg_we_i,
  input  wire logic [glg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [glg_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  import glg_pkg::*;

  localparam int unsigned NSTG = 5;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic signed [DB_W-1:0] target_q, gate_q;
  logic [LIMIT_W-1:0]     limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RST;
      gate_q   <= GATE_RST;
      limit_q  <= LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TARGET: target_q <= cfg_wdata_i;
        CFG_GATE:   gate_q   <= cfg_wdata_i;
        CFG_LIMIT:  limit_q  <= cfg_wdata_i[LIMIT_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control: per-stage valid, ready ripples back
  // ---------------------------------------------------------------------
  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] ld;     // stage k loads this cycle

  always_comb begin
    ld[NSTG-1] = m_axis_tready_i | ~vld_q[NSTG-1];
    for (int k = NSTG-2; k >= 0; k--) begin
      ld[k] = ld[k+1] | ~vld_q[k];
    end
  end

  assign s_axis_tready_o = ld[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ld[0]) begin
        vld_q[0] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (ld[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: remove the log2 offset from the raw float bits
  // ---------------------------------------------------------------------
  logic signed [D_W-1:0] d_d, d_q;

  assign d_d = D_W'($signed({1'b0, s_axis_tdata_i[POWER_W-1:0]}))
             - $signed(LOG_OFFSET_INT);

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      d_q <= d_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: scale to 1/256 dB (32 x 31 signed multiply)
  // ---------------------------------------------------------------------
  logic signed [LPROD_W-1:0] lprod;

  glg_mul #(
    .AW (D_W),
    .BW (LCOEF_W)
  ) u_lmul (
    .clk_i (clk_i),
    .en_i  (ld[1]),
    .a_i   (d_q),
    .b_i   (LEVEL_COEF),
    .p_o   (lprod)
  );

  // ---------------------------------------------------------------------
  // Stage 3: round to level, gate compare, gain = target - level, clamp
  // ---------------------------------------------------------------------
  logic signed [LPROD_W-1:0] lrnd;
  logic signed [LEVEL_W-1:0] lvl_d;
  logic signed [DIFF_W-1:0]  diff, lim_pos, lim_neg;
  logic                      gated_d;
  logic signed [DB_W-1:0]    g_d;
  logic signed [LEVEL_W-1:0] lvl3_q;
  logic                      gated3_q;
  logic signed [DB_W-1:0]    g_q;

  always_comb begin
    // round half up, then floor shift
    lrnd    = lprod + (LPROD_W'(1) <<< (LSHIFT-1));
    lvl_d   = lrnd[LSHIFT+LEVEL_W-1:LSHIFT];
    gated_d = lvl_d <= LEVEL_W'(gate_q);
    diff    = DIFF_W'(target_q) - DIFF_W'(lvl_d);
    lim_pos = $signed({{(DIFF_W-LIMIT_W){1'b0}}, limit_q});
    lim_neg = -lim_pos;
    if (gated_d) begin
      g_d = '0;
    end else if (diff > lim_pos) begin
      g_d = lim_pos[DB_W-1:0];
    end else if (diff < lim_neg) begin
      g_d = lim_neg[DB_W-1:0];
    end else begin
      g_d = diff[DB_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      lvl3_q   <= lvl_d;
      gated3_q <= gated_d;
      g_q      <= g_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: gain dB to log2 domain (16 x 30 signed multiply)
  // ---------------------------------------------------------------------
  logic signed [GPROD_W-1:0] gprod;
  logic signed [LEVEL_W-1:0] lvl4_q;
  logic                      gated4_q;

  glg_mul #(
    .AW (DB_W),
    .BW (GCOEF_W)
  ) u_gmul (
    .clk_i (clk_i),
    .en_i  (ld[3]),
    .a_i   (g_q),
    .b_i   (GAIN_COEF),
    .p_o   (gprod)
  );

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      lvl4_q   <= lvl3_q;
      gated4_q <= gated3_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: add fraction, floor shift, add integer offset -> float bits
  // ---------------------------------------------------------------------
  logic signed [GPROD_W-1:0] gsum;
  logic [GAIN_W-1:0]         gain_d, gain_q;
  logic signed [LEVEL_W-1:0] lvl5_q;
  logic                      gated5_q;

  always_comb begin
    gsum   = gprod + GPROD_W'(LOG_OFFSET_FRAC);
    gain_d = GAIN_W'($signed(gsum[GPROD_W-1:GSHIFT])) + LOG_OFFSET_INT;
  end

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      gain_q   <= gain_d;
      lvl5_q   <= lvl4_q;
      gated5_q <= gated4_q;
    end
  end

  assign m_axis_tvalid_o = vld_q[NSTG-1];
  assign m_axis_tdata_o  = {(OUT_TDATA_W-GAIN_W-LEVEL_W)'(0), lvl5_q, gain_q};
  assign m_axis_tuser_o  = gated5_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // a gated result always carries the unity-gain pattern
  a_gated_unity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[GAIN_W-1:0] == LOG_OFFSET_INT)
    else $error("gated result without unity gain");

  // empty output stage means the whole pipe can move
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled while output stage empty");

  // clamped gain stays inside the limit
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> (DIFF_W'(g_q) <= lim_pos) && (DIFF_W'(g_q) >= lim_neg))
    else $error("gain outside clamp");

  // a new output result comes from a valid stage 4
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(vld_q[NSTG-2]))
    else $error("output valid without upstream item");

endmodule : gated_level_to_gain

`default_nettype wire

// ===== dv/gain_checker.sv =====
// gain_checker: watches the input, output and config channels of gated_level_to_gain,
// predicts each result from the request and compares it. Depends on glg_pkg.
`default_nettype none

module gain_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  input  wire logic                            s_axis_tready_i,
  // [30:0] power_bits, [31] pad
  input  wire logic [glg_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  wire logic                            m_axis_tvalid_i,
  input  wire logic                            m_axis_tready_i,
  // [31:0] gain_bits, [49:32] level_db, [55:50] pad
  input  wire logic [glg_pkg::OUT_TDATA_W-1:0] m_axis_tdata_i,
  // [0] gated
  input  wire logic                            m_axis_tuser_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [glg_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [glg_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output int                                   pending_o,
  output int                                   fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import glg_pkg::*;

  // independent copies of the scale constants
  localparam longint LOG_BIAS   = 64'sd1064872507;  // 126.94269504 * 2^23
  localparam longint BIAS_FRAC  = 64'sd10093;       // Q16 fraction of the bias
  localparam longint DB_PER_LSB = 64'sd808071242;   // 10*log10(2)*256*2^20
  localparam longint EXP_PER_DB = 64'sd356689313;   // 2^23*log2(10)/5120, Q16

  typedef struct {
    logic [31:0]        gain_bits;
    logic signed [17:0] level_db;
    logic               gated;
  } gain_result_t;

  logic signed [15:0] target_db;
  logic signed [15:0] gate_db;
  logic [14:0]        limit_db;
  gain_result_t       expected_gains [$];
  int                 mismatch_count;

  function automatic gain_result_t predict_gain(logic [30:0] power_bits);
    longint       d;
    longint       level;
    longint       g;
    longint       lim;
    longint       gain;
    gain_result_t r;
    d     = longint'(power_bits) - LOG_BIAS;
    level = (d * DB_PER_LSB + (64'sd1 <<< 42)) >>> 43;  // round half up
    lim   = longint'(limit_db);
    g     = 0;
    r.gated = (level <= longint'(gate_db));
    if (!r.gated) begin
      g = longint'(target_db) - level;
      if (g > lim) g = lim;
      if (g < -lim) g = -lim;
    end
    gain        = LOG_BIAS + ((g * EXP_PER_DB + BIAS_FRAC) >>> 16);
    r.gain_bits = gain[31:0];
    r.level_db  = level[17:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    gain_result_t exp_r;
    logic [31:0]  act_gain;
    logic [17:0]  act_level;
    if (!rst_ni) begin
      target_db      <= TARGET_RST;
      gate_db        <= GATE_RST;
      limit_db       <= LIMIT_RST;
      expected_gains.delete();
      mismatch_count <= 0;
      pending_o      <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TARGET: target_db <= cfg_wdata_i;
          CFG_GATE:   gate_db   <= cfg_wdata_i;
          CFG_LIMIT:  limit_db  <= cfg_wdata_i[14:0];
          default: ;  // unmapped index, ignored
        endcase
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        act_gain  = m_axis_tdata_i[31:0];
        act_level = m_axis_tdata_i[49:32];
        if (expected_gains.size() == 0) begin
          if (mismatch_count < 10)
            $display("[%0t] unexpected result gain=%h level=%h gated=%b",
                     $realtime, act_gain, act_level, m_axis_tuser_i);
          mismatch_count <= mismatch_count + 1;
        end else begin
          exp_r = expected_gains.pop_front();
          if (act_gain !== exp_r.gain_bits || act_level !== exp_r.level_db ||
              m_axis_tuser_i !== exp_r.gated) begin
            if (mismatch_count < 10)
              $display({"[%0t] mismatch: gain exp %h act %h, level exp %h act %h,",
                        " gated exp %b act %b"},
                       $realtime, exp_r.gain_bits, act_gain, exp_r.level_db, act_level,
                       exp_r.gated, m_axis_tuser_i);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        expected_gains.push_back(predict_gain(s_axis_tdata_i[30:0]));
      pending_o <= expected_gains.size();
    end
  end

  assign fail_count_o = mismatch_count;

endmodule : gain_checker

`default_nettype wire

// ===== dv/gated_level_to_gain_tb.sv =====
// gated_level_to_gain_tb: stimulus and verdict for gated_level_to_gain.
// Depends on glg_pkg, the block itself and gain_checker, which does the checking.
`default_nettype none

module gated_level_to_gain_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import glg_pkg::*;

  // unmapped register index, the block must ignore writes to it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  // 1/256 dB scale per input LSB in Q43, used only to aim requests at the gate
  localparam longint DB_PER_LSB = 64'sd808071242;
  localparam int     NUM_PHASES = 6;
  localparam int     RANDOM_PER_PHASE = 200;
  // float edge patterns: zero, smallest/largest denormal, smallest normal,
  // 1.0 and just below, largest finite, infinity, NaNs, alternating bits
  localparam logic [30:0] EDGE_BITS [12] = '{
    31'h0000_0000, 31'h0000_0001, 31'h007F_FFFF, 31'h0080_0000,
    31'h3F80_0000, 31'h3F7F_FFFF, 31'h7F7F_FFFF, 31'h7F80_0000,
    31'h7FC0_0000, 31'h7FFF_FFFF, 31'h2AAA_AAAA, 31'h5555_5555
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tuser_o;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i;
  int                     pending;
  int                     fail_count;

  // stimulus state
  int                 burst_left;
  logic signed [15:0] cur_gate;
  longint             gate_offset;  // input offset from the log bias that lands on the gate

  gated_level_to_gain u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  gain_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .pending_o       (pending),
    .fail_count_o    (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: runs of ready and stall of random length. Stalls are kept short,
  // ready runs longer, and now and then a long stretch with no stall at all.
  initial begin
    logic hold;
    int   len;
    forever begin
      hold = ($urandom_range(0, 3) != 0);
      len  = hold ? $urandom_range(1, 24) : $urandom_range(1, 8);
      if ($urandom_range(0, 15) == 0) begin
        hold = 1'b1;
        len  = 64;
      end
      repeat (len) begin
        m_axis_tready_i <= hold;
        @(posedge clk_i);
      end
    end
  end

  // Present one request and hold it until accepted. A new burst may open with
  // a gap; about one burst in four follows the last with no gap at all.
  task automatic send_item(input logic [30:0] bits);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, bits};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Wait for every outstanding result, then let the pipeline settle.
  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // One write request per cycle; the caller lowers the enable afterwards.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic signed [15:0] tgt, input logic signed [15:0] gate,
                           input logic [14:0] lim);
    // spare index first so a wrongly decoded write would corrupt a live register
    write_reg(CFG_SPARE, 16'($urandom));
    write_reg(CFG_TARGET, tgt);
    write_reg(CFG_GATE, gate);
    // bit 15 is outside the limit register, toggle it anyway
    write_reg(CFG_LIMIT, {1'($urandom), lim});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    cur_gate    = gate;
    gate_offset = (longint'(gate) * (64'sd1 <<< 43)) / DB_PER_LSB;
  endtask

  // Requests straddling the gate so the level lands on it exactly at least once.
  task automatic gate_sweep();
    for (int k = -3; k <= 3; k++)
      send_item(31'(longint'(LOG_OFFSET_INT) + gate_offset + k));
  endtask

  // Mostly realistic levels spanning gate, target and both clamps; some fully
  // random patterns and some aimed close to the gate.
  task automatic send_random();
    int          mode;
    longint      d;
    logic [30:0] bits;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      bits = 31'($urandom);
    end else if (mode < 8) begin
      d    = longint'($urandom_range(0, 32'h4000_0000)) - 64'sd536870912;
      bits = 31'(longint'(LOG_OFFSET_INT) + d);
    end else begin
      d    = gate_offset + longint'($urandom_range(0, 32'h0080_0000)) - 64'sd4194304;
      bits = 31'(longint'(LOG_OFFSET_INT) + d);
    end
    send_item(bits);
  endtask

  initial begin
    logic signed [15:0] tgt;
    logic signed [15:0] gate;
    logic [14:0]        lim;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= CFG_TARGET;
    cfg_wdata_i     <= '0;
    burst_left  = 0;
    cur_gate    = GATE_RST;
    gate_offset = (longint'(cur_gate) * (64'sd1 <<< 43)) / DB_PER_LSB;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // phase 0 runs on the reset values of the registers
      if (phase > 0) begin
        drain();
        case (phase)
          1: begin tgt = -16'sd4608;  gate = -16'sd15360; lim = 15'd0;     end
          2: begin tgt = 16'sd32767;  gate = -16'sd32768; lim = 15'd32767; end
          3: begin tgt = -16'sd32768; gate = 16'sd32767;  lim = 15'd32767; end
          default: begin
            tgt  = 16'($urandom);
            gate = 16'($urandom_range(0, 16'hFFFF));
            lim  = 15'($urandom_range(0, 32767));
          end
        endcase
        configure(tgt, gate, lim);
      end
      gate_sweep();
      if (phase == 0)
        foreach (EDGE_BITS[i]) send_item(EDGE_BITS[i]);
      repeat (RANDOM_PER_PHASE) send_random();
      s_axis_tvalid_i <= 1'b0;
      burst_left = 0;
    end

    drain();
    if (fail_count == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule : gated_level_to_gain_tb

`default_nettype wire
